// ===== rtl/radar_speed_frame_vehicle_stats_assert.svh =====
// Assertion macros for the radar speed statistics block.
`ifndef RADAR_SPEED_FRAME_VEHICLE_STATS_ASSERT_SVH
`define RADAR_SPEED_FRAME_VEHICLE_STATS_ASSERT_SVH
`ifndef SYNTHESIS
`define RSFVS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`define RSFVS_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
`else
`define RSFVS_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`define RSFVS_ASSERT_NOW(lbl, clk, rstn, ante, cons)
`endif
`endif

// ===== rtl/rsfvs_pkg.sv =====
package rsfvs_pkg;
    localparam int LINE_CHARS_MAX_DEF = 15;
    localparam int COUNT_BITS_DEF     = 24;
    localparam int LINE_MIN           = 7;
    localparam int OUT_COUNT_W        = 24;

    localparam logic [7:0] CH_V     = 8'h56;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam logic [1:0] CMD_BYTE  = 2'd0;
    localparam logic [1:0] CMD_TICK  = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    localparam logic [1:0] KIND_READING = 2'd0;
    localparam logic [1:0] KIND_LOST    = 2'd1;
    localparam logic [1:0] KIND_RESET   = 2'd2;

    localparam logic [1:0] REG_MIN     = 2'd0;
    localparam logic [1:0] REG_MAX     = 2'd1;
    localparam logic [1:0] REG_GAP     = 2'd2;
    localparam logic [1:0] REG_TIMEOUT = 2'd3;

    typedef enum logic [2:0] {
        PH_HEADER, PH_SIGN, PH_PRE, PH_INT, PH_DOT_EMPTY, PH_DOT_INT, PH_DONE
    } phase_t;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_EXEC  = 4'b0010,
        ST_START = 4'b0100,
        ST_DIV   = 4'b1000
    } state_t;

    typedef struct packed {
        logic load;
        logic exec;
        logic div_start;
        logic out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic has_result;
        logic div_busy;
        logic out_free;
    } ctrl_stat_t;
endpackage

// ===== rtl/rsfvs_div.sv =====
module rsfvs_div import rsfvs_pkg::*; #(
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic [COUNT_BITS+15:0]  dividend,
    input  logic [COUNT_BITS-1:0]   divisor,
    output logic                    busy,
    output logic [15:0]             quotient
);
    localparam int SUM_BITS = COUNT_BITS + 16;
    localparam int CNT_W    = $clog2(SUM_BITS + 1);

    logic                  busy_reg, busy_next;
    logic                  zero_reg, zero_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [COUNT_BITS:0]   rem_reg, rem_next;
    logic [SUM_BITS-1:0]   quo_reg, quo_next;
    logic [COUNT_BITS-1:0] dvs_reg, dvs_next;
    logic [COUNT_BITS:0]   shifted;
    logic                  ge;

    assign shifted = {rem_reg[COUNT_BITS-1:0], quo_reg[SUM_BITS-1]};
    assign ge      = shifted >= {1'b0, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        zero_next = zero_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            zero_next = (divisor == '0);
            cnt_next  = CNT_W'(SUM_BITS);
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? (shifted - {1'b0, dvs_reg}) : shifted;
            quo_next = {quo_reg[SUM_BITS-2:0], ge};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        zero_reg <= zero_next;
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        dvs_reg  <= dvs_next;
    end

    assign busy     = busy_reg;
    assign quotient = zero_reg ? 16'd0 : quo_reg[15:0];
endmodule

// ===== rtl/rsfvs_ctrl.sv =====
module rsfvs_ctrl import rsfvs_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  ctrl_stat_t stat,
    output ctrl_cmd_t  cmd
);
    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = stat.has_result ? ST_START : ST_IDLE;
            end
            ST_START:
            begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIV;
            end
            ST_DIV:
            begin
                if (!stat.div_busy && stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end
endmodule

// ===== rtl/rsfvs_dp.sv =====
module rsfvs_dp import rsfvs_pkg::*; #(
    parameter int LINE_CHARS_MAX = LINE_CHARS_MAX_DEF,
    parameter int COUNT_BITS     = COUNT_BITS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  ctrl_cmd_t    cmd,
    output ctrl_stat_t   stat,
    input  logic [1:0]   in_command,
    input  logic [7:0]   in_byte,
    input  logic [15:0]  min_speed,
    input  logic [15:0]  max_speed,
    input  logic [15:0]  gap_ms,
    input  logic [15:0]  timeout_ms,
    output logic         out_valid,
    input  logic         out_ready,
    output logic [127:0] out_data,
    output logic [1:0]   out_kind
);
    localparam int LEN_W    = $clog2(LINE_CHARS_MAX + 1);
    localparam int SUM_BITS = COUNT_BITS + 16;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    // pending word
    logic [1:0]  cmd_reg;
    logic [7:0]  byte_reg;

    // line parser
    logic [LEN_W-1:0] len_reg, len_next;
    phase_t           phase_reg, phase_next;
    logic             bad_reg, bad_next;
    logic             dir_reg, dir_next;
    logic [15:0]      acc_reg, acc_next;

    // timing and vehicle tracking
    logic [31:0] now_reg, now_next;
    logic        det_reg, det_next;
    logic [31:0] last_det_reg, last_det_next;
    logic        seen_reg, seen_next;
    logic [31:0] last_veh_reg, last_veh_next;
    logic        pdir_reg, pdir_next;
    logic [15:0] pspd_reg, pspd_next;

    // statistics
    logic [COUNT_BITS-1:0] tot_reg, tot_next;
    logic [COUNT_BITS-1:0] tow_reg, tow_next;
    logic [COUNT_BITS-1:0] away_reg, away_next;
    logic [SUM_BITS-1:0]   sum_reg, sum_next;
    logic [15:0]           top_reg, top_next;

    // result snapshot
    logic [1:0]  rk_reg, rk_next;
    logic [15:0] rspd_reg, rspd_next;
    logic        rapp_reg, rapp_next;
    logic        rdet_reg, rdet_next;
    logic        rnew_reg, rnew_next;

    logic         ov_reg;
    logic [127:0] od_reg;
    logic [1:0]   ok_reg;

    logic        has_res;
    logic        digit;
    logic [3:0]  d;
    logic [20:0] mac;
    logic [16:0] add_frac;
    logic [15:0] spd_mul;
    logic [15:0] spd_add;
    logic        line_ok;
    logic        is_new;
    logic [15:0] avg;
    logic        div_busy;

    assign digit    = (byte_reg >= CH_ZERO) && (byte_reg <= CH_NINE);
    assign d        = digit ? 4'(byte_reg - CH_ZERO) : 4'd0;
    assign mac      = 21'(acc_reg) * 21'd10 + 21'(d) * 21'd10;
    assign spd_mul  = (mac > 21'hFFFF) ? 16'hFFFF : mac[15:0];
    assign add_frac = 17'(acc_reg) + 17'(d);
    assign spd_add  = add_frac[16] ? 16'hFFFF : add_frac[15:0];
    assign line_ok  = !bad_reg && (len_reg >= LEN_W'(LINE_MIN)) &&
                      (phase_reg == PH_INT || phase_reg == PH_DOT_INT || phase_reg == PH_DONE);
    assign is_new   = !seen_reg || ((now_reg - last_veh_reg) > 32'(gap_ms)) ||
                      (dir_reg != pdir_reg);

    always_comb
    begin
        len_next      = len_reg;
        phase_next    = phase_reg;
        bad_next      = bad_reg;
        dir_next      = dir_reg;
        acc_next      = acc_reg;
        now_next      = now_reg;
        det_next      = det_reg;
        last_det_next = last_det_reg;
        seen_next     = seen_reg;
        last_veh_next = last_veh_reg;
        pdir_next     = pdir_reg;
        pspd_next     = pspd_reg;
        tot_next      = tot_reg;
        tow_next      = tow_reg;
        away_next     = away_reg;
        sum_next      = sum_reg;
        top_next      = top_reg;
        rk_next       = rk_reg;
        rspd_next     = 16'd0;
        rapp_next     = 1'b0;
        rdet_next     = 1'b0;
        rnew_next     = 1'b0;
        has_res       = 1'b0;

        unique case (cmd_reg)
            CMD_BYTE:
            begin
                if (byte_reg == CH_LF)
                begin
                    len_next   = '0;
                    phase_next = PH_HEADER;
                    bad_next   = 1'b0;
                    dir_next   = 1'b0;
                    acc_next   = '0;
                    if (line_ok && acc_reg >= min_speed && acc_reg <= max_speed)
                    begin
                        has_res = 1'b1;
                        if (is_new)
                        begin
                            if (tot_reg != COUNT_MAX)
                                sum_next = sum_reg + SUM_BITS'(acc_reg);
                            if (tot_reg != COUNT_MAX)
                                tot_next = tot_reg + 1'b1;
                            if (dir_reg && tow_reg != COUNT_MAX)
                                tow_next = tow_reg + 1'b1;
                            if (!dir_reg && away_reg != COUNT_MAX)
                                away_next = away_reg + 1'b1;
                            if (acc_reg > top_reg)
                                top_next = acc_reg;
                            last_veh_next = now_reg;
                            seen_next     = 1'b1;
                        end
                        else if (acc_reg > pspd_reg && acc_reg > top_reg)
                            top_next = acc_reg;
                        last_det_next = now_reg;
                        det_next      = 1'b1;
                        pspd_next     = acc_reg;
                        pdir_next     = dir_reg;
                        rk_next       = KIND_READING;
                        rspd_next     = acc_reg;
                        rapp_next     = dir_reg;
                        rdet_next     = 1'b1;
                        rnew_next     = is_new;
                    end
                end
                else if (byte_reg != CH_CR && len_reg < LEN_W'(LINE_CHARS_MAX))
                begin
                    len_next = len_reg + 1'b1;
                    if (!bad_reg)
                    begin
                        unique case (phase_reg)
                            PH_HEADER:
                                if (byte_reg == CH_V) phase_next = PH_SIGN;
                                else bad_next = 1'b1;
                            PH_SIGN:
                                if (byte_reg == CH_PLUS || byte_reg == CH_MINUS)
                                begin
                                    dir_next   = (byte_reg == CH_PLUS);
                                    phase_next = PH_PRE;
                                end
                                else bad_next = 1'b1;
                            PH_PRE:
                                if (byte_reg == CH_SPACE || byte_reg == CH_TAB)
                                    phase_next = PH_PRE;
                                else if (digit)
                                begin
                                    acc_next   = 16'(d) * 16'd10;
                                    phase_next = PH_INT;
                                end
                                else if (byte_reg == CH_DOT) phase_next = PH_DOT_EMPTY;
                                else bad_next = 1'b1;
                            PH_INT:
                                if (digit) acc_next = spd_mul;
                                else if (byte_reg == CH_DOT) phase_next = PH_DOT_INT;
                                else phase_next = PH_DONE;
                            PH_DOT_EMPTY:
                                if (digit)
                                begin
                                    acc_next   = spd_add;
                                    phase_next = PH_DONE;
                                end
                                else bad_next = 1'b1;
                            PH_DOT_INT:
                            begin
                                if (digit) acc_next = spd_add;
                                phase_next = PH_DONE;
                            end
                            default: phase_next = phase_reg;
                        endcase
                    end
                end
            end
            CMD_TICK:
            begin
                now_next = now_reg + 32'd1;
                if (det_reg && ((now_next - last_det_reg) > 32'(timeout_ms)))
                begin
                    has_res       = 1'b1;
                    det_next      = 1'b0;
                    last_det_next = '0;
                    rk_next       = KIND_LOST;
                end
            end
            CMD_CLEAR:
            begin
                has_res       = 1'b1;
                tot_next      = '0;
                tow_next      = '0;
                away_next     = '0;
                sum_next      = '0;
                top_next      = '0;
                seen_next     = 1'b0;
                last_veh_next = '0;
                rk_next       = KIND_RESET;
                rdet_next     = det_reg;
            end
            default: has_res = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg      <= '0;
            phase_reg    <= PH_HEADER;
            bad_reg      <= 1'b0;
            dir_reg      <= 1'b0;
            acc_reg      <= '0;
            now_reg      <= '0;
            det_reg      <= 1'b0;
            last_det_reg <= '0;
            seen_reg     <= 1'b0;
            last_veh_reg <= '0;
            pdir_reg     <= 1'b0;
            pspd_reg     <= '0;
            tot_reg      <= '0;
            tow_reg      <= '0;
            away_reg     <= '0;
            sum_reg      <= '0;
            top_reg      <= '0;
            ov_reg       <= 1'b0;
        end
        else
        begin
            if (cmd.exec)
            begin
                len_reg      <= len_next;
                phase_reg    <= phase_next;
                bad_reg      <= bad_next;
                dir_reg      <= dir_next;
                acc_reg      <= acc_next;
                now_reg      <= now_next;
                det_reg      <= det_next;
                last_det_reg <= last_det_next;
                seen_reg     <= seen_next;
                last_veh_reg <= last_veh_next;
                pdir_reg     <= pdir_next;
                pspd_reg     <= pspd_next;
                tot_reg      <= tot_next;
                tow_reg      <= tow_next;
                away_reg     <= away_next;
                sum_reg      <= sum_next;
                top_reg      <= top_next;
            end
            if (cmd.out_load)
                ov_reg <= 1'b1;
            else if (out_ready)
                ov_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cmd_reg  <= in_command;
            byte_reg <= in_byte;
        end
        if (cmd.exec)
        begin
            rk_reg   <= rk_next;
            rspd_reg <= rspd_next;
            rapp_reg <= rapp_next;
            rdet_reg <= rdet_next;
            rnew_reg <= rnew_next;
        end
        if (cmd.out_load)
        begin
            ok_reg <= rk_reg;
            od_reg <= {5'd0, top_reg, avg,
                       OUT_COUNT_W'(away_reg), OUT_COUNT_W'(tow_reg), OUT_COUNT_W'(tot_reg),
                       rnew_reg, rdet_reg, rapp_reg, rspd_reg};
        end
    end

    rsfvs_div #(.COUNT_BITS(COUNT_BITS)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (sum_reg),
        .divisor  (tot_reg),
        .busy     (div_busy),
        .quotient (avg)
    );

    assign stat.has_result = has_res;
    assign stat.div_busy   = div_busy;
    assign stat.out_free   = !ov_reg || out_ready;
    assign out_valid       = ov_reg;
    assign out_data        = od_reg;
    assign out_kind        = ok_reg;
endmodule

// ===== rtl/radar_speed_frame_vehicle_stats.sv =====
// Sequence: an accepted word is loaded and executed; a word that yields no result ends there;
//   one with a result starts the bit-serial divider and is shown once the quotient is done.
// One word at a time: a result waits for a free output register before a new word is taken.
// Reset: rst_n async active low; clears parser, timers, statistics and config to defaults.
// No clearing pass: the block takes words right after reset.
`include "radar_speed_frame_vehicle_stats_assert.svh"
module radar_speed_frame_vehicle_stats import rsfvs_pkg::*; #(
    parameter int LINE_CHARS_MAX = LINE_CHARS_MAX_DEF,
    parameter int COUNT_BITS     = COUNT_BITS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,  // [7:0] byte_value
    input  logic [1:0]   s_tuser,  // [1:0] command
    output logic         m_tvalid,
    input  logic         m_tready,
    // [15:0] speed_tenths, [16] approaching, [17] detected, [18] new_vehicle,
    // [42:19] vehicle_count, [66:43] approaching_count, [90:67] leaving_count,
    // [106:91] average_tenths, [122:107] max_tenths, rest zero
    output logic [127:0] m_tdata,
    output logic [1:0]   m_tuser,  // [1:0] kind
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    // threshold, gap and timeout registers
    logic [15:0] min_reg, max_reg, gap_reg, tmo_reg;
    logic        wr_en;
    ctrl_cmd_t   ctrl_cmd;
    ctrl_stat_t  ctrl_stat;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg <= 16'd50;
            max_reg <= 16'd2500;
            gap_reg <= 16'd2000;
            tmo_reg <= 16'd1000;
        end
        else if (wr_en)
        begin
            unique case (paddr[3:2])
                REG_MIN:     min_reg <= pwdata[15:0];
                REG_MAX:     max_reg <= pwdata[15:0];
                REG_GAP:     gap_reg <= pwdata[15:0];
                REG_TIMEOUT: tmo_reg <= pwdata[15:0];
                default:     min_reg <= min_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_MIN:     prdata = {16'd0, min_reg};
            REG_MAX:     prdata = {16'd0, max_reg};
            REG_GAP:     prdata = {16'd0, gap_reg};
            REG_TIMEOUT: prdata = {16'd0, tmo_reg};
            default:     prdata = '0;
        endcase
    end

    // sequencer: load, execute, start divide, wait and hand to output register
    rsfvs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .stat     (ctrl_stat),
        .cmd      (ctrl_cmd)
    );

    // parser, vehicle tracker, statistics, divider and output register
    rsfvs_dp #(
        .LINE_CHARS_MAX (LINE_CHARS_MAX),
        .COUNT_BITS     (COUNT_BITS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (ctrl_cmd),
        .stat       (ctrl_stat),
        .in_command (s_tuser),
        .in_byte    (s_tdata),
        .min_speed  (min_reg),
        .max_speed  (max_reg),
        .gap_ms     (gap_reg),
        .timeout_ms (tmo_reg),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_data   (m_tdata),
        .out_kind   (m_tuser)
    );

    // one word in flight: no accept right after an accept
    `RSFVS_ASSERT_NEXT(a_one_word, clk, rst_n, s_tvalid && s_tready, !s_tready)
    // output register loads only with a finished quotient
    `RSFVS_ASSERT_NOW(a_div_done, clk, rst_n, ctrl_cmd.out_load, !ctrl_stat.div_busy)
    // a detection-cleared word carries no speed and no detection
    `RSFVS_ASSERT_NOW(a_lost_clear, clk, rst_n, m_tvalid && m_tuser == KIND_LOST,
        m_tdata[17] == 1'b0 && m_tdata[15:0] == 16'd0)
endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps

// Holds the expected output words of the radar speed block and checks the
// words that come out against them, oldest first.
class speed_scoreboard;
    logic [1:0]   kind_q[$];
    logic [127:0] data_q[$];
    int           errors;
    int           mismatches;

    function new();
        errors = 0;
        mismatches = 0;
    endfunction

    // note the word the predictor says an accepted input will produce
    function void note_input(logic [1:0] kind, logic [127:0] data);
        kind_q.push_back(kind);
        data_q.push_back(data);
    endfunction

    function void check_result(logic [1:0] kind, logic [127:0] data);
        logic [1:0]   exp_kind;
        logic [127:0] exp_data;
        if (kind_q.size() == 0)
        begin
            errors++;
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected output word kind=%0d data=%h", kind, data);
            return;
        end
        exp_kind = kind_q.pop_front();
        exp_data = data_q.pop_front();
        if (kind !== exp_kind || data !== exp_data)
        begin
            errors++;
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch: exp kind=%0d data=%h, got kind=%0d data=%h",
                         exp_kind, exp_data, kind, data);
        end
    endfunction

    function int pending();
        return kind_q.size();
    endfunction
endclass

module tb_top;
    import rsfvs_pkg::*;

    localparam logic [23:0] COUNT_MAX  = 24'hFFFFFF;
    localparam int          LATENCY    = 60;
    localparam logic [1:0]  CMD_UNUSED = 2'd3;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [7:0]   s_tdata;
    logic [1:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [127:0] m_tdata;
    logic [1:0]   m_tuser;
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [3:0]   paddr;
    logic [31:0]  pwdata;
    logic [31:0]  prdata;
    logic         pready;

    radar_speed_frame_vehicle_stats u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    speed_scoreboard sb;

    // idle / stall rates in percent, changed per phase
    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;
    // long receiver hold-off, counted down in the receive process
    int unsigned hold_cycles;

    // ---------------- predictor state ----------------
    logic [15:0] cfg_min, cfg_max, cfg_gap, cfg_timeout;
    logic [3:0]  line_len;
    phase_t      phase;
    logic        line_rejected;
    logic        line_dir;
    logic [15:0] accum;
    logic [31:0] clock_ms;
    logic        detect_on;
    logic [31:0] detect_ms;
    logic        vehicle_open;
    logic [31:0] vehicle_ms;
    logic        prev_dir;
    logic [15:0] prev_speed;
    logic [23:0] n_total, n_toward, n_away;
    logic [39:0] sum_speed;
    logic [15:0] peak_speed;

    function automatic logic [15:0] sat16(logic [31:0] v);
        return (v > 32'hFFFF) ? 16'hFFFF : v[15:0];
    endfunction

    function automatic logic [23:0] bump(logic [23:0] c);
        return (c == COUNT_MAX) ? c : c + 24'd1;
    endfunction

    task automatic reset_predictor();
        cfg_min = 16'd50;
        cfg_max = 16'd2500;
        cfg_gap = 16'd2000;
        cfg_timeout = 16'd1000;
        line_len = 0;
        phase = PH_HEADER;
        line_rejected = 0;
        line_dir = 0;
        accum = 0;
        clock_ms = 0;
        detect_on = 0;
        detect_ms = 0;
        vehicle_open = 0;
        vehicle_ms = 0;
        prev_dir = 0;
        prev_speed = 0;
        n_total = 0;
        n_toward = 0;
        n_away = 0;
        sum_speed = 0;
        peak_speed = 0;
    endtask

    // one character of the line parser
    task automatic parse_char(logic [7:0] c);
        logic       is_digit;
        logic [3:0] d;
        is_digit = (c >= CH_ZERO && c <= CH_NINE);
        d = is_digit ? 4'(c - CH_ZERO) : 4'd0;
        if (line_rejected)
            return;
        case (phase)
            PH_HEADER:
                if (c == CH_V) phase = PH_SIGN; else line_rejected = 1;
            PH_SIGN:
                if (c == CH_PLUS || c == CH_MINUS)
                begin
                    line_dir = (c == CH_PLUS);
                    phase = PH_PRE;
                end
                else line_rejected = 1;
            PH_PRE:
                if (c == CH_SPACE || c == CH_TAB)
                    ;
                else if (is_digit)
                begin
                    accum = sat16(32'(d) * 10);
                    phase = PH_INT;
                end
                else if (c == CH_DOT) phase = PH_DOT_EMPTY;
                else line_rejected = 1;
            PH_INT:
                if (is_digit) accum = sat16(32'(accum) * 10 + 32'(d) * 10);
                else if (c == CH_DOT) phase = PH_DOT_INT;
                else phase = PH_DONE;
            PH_DOT_EMPTY:
                if (is_digit)
                begin
                    accum = sat16(32'(accum) + 32'(d));
                    phase = PH_DONE;
                end
                else line_rejected = 1;
            PH_DOT_INT:
            begin
                if (is_digit) accum = sat16(32'(accum) + 32'(d));
                phase = PH_DONE;
            end
            default: ;
        endcase
    endtask

    function automatic logic [127:0] stats_word(logic [15:0] spd, logic appr, logic det,
                                                logic fresh);
        logic [127:0] w;
        logic [39:0]  avg;
        avg = (n_total != 0) ? sum_speed / n_total : 40'd0;
        w = '0;
        w[15:0]    = spd;
        w[16]      = appr;
        w[17]      = det;
        w[18]      = fresh;
        w[42:19]   = n_total;
        w[66:43]   = n_toward;
        w[90:67]   = n_away;
        w[106:91]  = avg[15:0];
        w[122:107] = peak_speed;
        return w;
    endfunction

    // advance the predictor by one accepted word, queue any expected output
    task automatic predict_word(logic [1:0] cmd, logic [7:0] c);
        logic        ok;
        logic [15:0] spd;
        logic        dir;
        logic        fresh;
        if (cmd == CMD_BYTE)
        begin
            if (c == CH_LF)
            begin
                ok = !line_rejected && line_len >= LINE_MIN &&
                     (phase == PH_INT || phase == PH_DOT_INT || phase == PH_DONE);
                spd = accum;
                dir = line_dir;
                line_len = 0;
                phase = PH_HEADER;
                line_rejected = 0;
                line_dir = 0;
                accum = 0;
                if (!ok || spd < cfg_min || spd > cfg_max)
                    return;
                fresh = !vehicle_open || (clock_ms - vehicle_ms) > 32'(cfg_gap) ||
                        dir != prev_dir;
                if (fresh)
                begin
                    if (n_total != COUNT_MAX) sum_speed += 40'(spd);
                    n_total = bump(n_total);
                    if (dir) n_toward = bump(n_toward);
                    else n_away = bump(n_away);
                    if (spd > peak_speed) peak_speed = spd;
                    vehicle_ms = clock_ms;
                    vehicle_open = 1;
                end
                else if (spd > prev_speed && spd > peak_speed)
                    peak_speed = spd;
                detect_ms = clock_ms;
                detect_on = 1;
                prev_speed = spd;
                prev_dir = dir;
                sb.note_input(KIND_READING, stats_word(spd, dir, 1'b1, fresh));
            end
            else if (c != CH_CR && line_len < LINE_CHARS_MAX_DEF)
            begin
                parse_char(c);
                line_len++;
            end
        end
        else if (cmd == CMD_TICK)
        begin
            clock_ms++;
            if (detect_on && (clock_ms - detect_ms) > 32'(cfg_timeout))
            begin
                detect_on = 0;
                detect_ms = 0;
                sb.note_input(KIND_LOST, stats_word(16'd0, 1'b0, 1'b0, 1'b0));
            end
        end
        else if (cmd == CMD_CLEAR)
        begin
            n_total = 0;
            n_toward = 0;
            n_away = 0;
            sum_speed = 0;
            peak_speed = 0;
            vehicle_open = 0;
            vehicle_ms = 0;
            sb.note_input(KIND_RESET, stats_word(16'd0, 1'b0, detect_on, 1'b0));
        end
        // command 3 is ignored by the block
    endtask

    // ---------------- clock, reset, timeout ----------------
    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("FAILED: results differ");
        $finish;
    end

    // ---------------- bus drivers ----------------
    // tvalid stays up after an accept; the next word replaces it, an idle cycle or drain drops it
    task automatic send_word(logic [1:0] cmd, logic [7:0] c);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 0;
            @(posedge clk);
        end
        s_tvalid <= 1;
        s_tuser  <= cmd;
        s_tdata  <= c;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predict_word(cmd, c);
    endtask

    task automatic send_text(string s);
        foreach (s[i])
            send_word(CMD_BYTE, s[i]);
    endtask

    task automatic send_ticks(int n);
        repeat (n)
            send_word(CMD_TICK, 8'($urandom));
    endtask

    // APB write: setup, then access, then back to idle; pready is always high
    task automatic write_reg(logic [1:0] idx, logic [15:0] value);
        psel    <= 1;
        penable <= 0;
        pwrite  <= 1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {16'($urandom), value};
        @(posedge clk);
        penable <= 1;
        @(posedge clk);
        psel    <= 0;
        penable <= 0;
        pwrite  <= 0;
        @(posedge clk);
        case (idx)
            REG_MIN:     cfg_min = value;
            REG_MAX:     cfg_max = value;
            REG_GAP:     cfg_gap = value;
            default:     cfg_timeout = value;
        endcase
    endtask

    // wait until every expected word has arrived, then let the block settle
    task automatic drain();
        int guard;
        guard = 0;
        s_tvalid <= 0;
        while (sb.pending() != 0 && guard < 200000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (LATENCY) @(posedge clk);
    endtask

    // random well-formed (mostly) reading line with random content
    task automatic send_reading();
        string s;
        int    r;
        s = {"V", string'(($urandom_range(1) != 0) ? "+" : "-")};
        repeat ($urandom_range(2)) s = {s, string'(($urandom_range(1) != 0) ? " " : "\t")};
        r = $urandom_range(9);
        if (r < 6)
            s = {s, $sformatf("%0d.%0d", $urandom_range(300), $urandom_range(9))};
        else if (r == 6)
            s = {s, $sformatf("%0d", $urandom_range(99999))};
        else if (r == 7)
            s = {s, $sformatf(".%0d", $urandom_range(9))};
        else if (r == 8)
            s = {s, $sformatf("%0d.%0de3", $urandom_range(9999), $urandom_range(99))};
        else
            s = {s, "12", string'(8'($urandom))};
        if ($urandom_range(4) == 0) s = {s, "\r"};
        s = {s, "\n"};
        // occasionally corrupt one character
        if ($urandom_range(9) == 0)
            s[$urandom_range(s.len() - 2)] = 8'($urandom);
        send_text(s);
    endtask

    task automatic random_word();
        int r;
        r = $urandom_range(99);
        if (r < 45)
            send_reading();
        else if (r < 80)
            send_ticks($urandom_range(1, 40));
        else if (r < 85)
            send_word(CMD_CLEAR, 8'($urandom));
        else if (r < 88)
            send_word(CMD_UNUSED, 8'($urandom));
        else
            send_word(CMD_BYTE, 8'($urandom));
    endtask

    // ---------------- receiver ----------------
    initial
    begin
        m_tready = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
                sb.check_result(m_tuser, m_tdata);
            if (hold_cycles != 0)
            begin
                hold_cycles--;
                m_tready <= 0;
            end
            else
                m_tready <= !(recv_stall_pct != 0 && $urandom_range(99) < recv_stall_pct);
        end
    end

    // ---------------- main sequence ----------------
    initial
    begin
        sb = new();
        rst_n = 0;
        s_tvalid = 0;
        s_tdata = 0;
        s_tuser = 0;
        psel = 0;
        penable = 0;
        pwrite = 0;
        paddr = 0;
        pwdata = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_cycles = 0;
        reset_predictor();
        repeat (12) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: good readings, window edges, malformed lines
        send_text("V+123.4\n");          // new vehicle, approaching
        send_text("V+130.9\r\n");        // same vehicle raises the max, CR ignored
        send_text("V-  42.0\n");         // direction change, blanks before number
        send_text("V-\t.5xx\n");         // no integer digits
        send_text("V+99999999\n");       // saturates, above max: dropped
        send_text("V+1.\n");             // too short
        send_text("V+ 7.\n");            // point with nothing after
        send_text("V++12.3\n");          // second sign
        send_text("X+123.4\n");          // bad header
        send_text("V-   .\n");           // lone point
        send_text("V+12.3e5 trailing junk here\n"); // exponent and overlong line
        drain();
        write_reg(REG_TIMEOUT, 16'd30);
        send_ticks(35);                  // detection timeout
        send_word(CMD_CLEAR, 8'hFF);
        send_word(CMD_UNUSED, 8'hA5);
        send_word(CMD_BYTE, 8'h00);
        drain();

        // window extremes
        write_reg(REG_MIN, 16'd0);
        write_reg(REG_MAX, 16'hFFFF);
        write_reg(REG_GAP, 16'd0);
        write_reg(REG_TIMEOUT, 16'd0);
        send_text("V+0.0\n");
        send_text("V+6553.5\n");
        send_text("V-999999\n");
        send_ticks(2);
        drain();

        for (int ph = 0; ph < 5; ph++)
        begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 47; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 47; end
                3: begin send_idle_pct = 16; recv_stall_pct = 16; end
                default: begin send_idle_pct = 0; recv_stall_pct = 0; end
            endcase
            write_reg(REG_MIN, (ph == 4) ? 16'hFFFF : 16'($urandom_range(100)));
            write_reg(REG_MAX, (ph == 1) ? 16'd0 : 16'($urandom_range(1500, 65535)));
            write_reg(REG_GAP, 16'($urandom_range(60)));
            write_reg(REG_TIMEOUT, 16'($urandom_range(40)));
            if (ph == 0)
                hold_cycles = 3000;    // receiver holds off; input backs up
            repeat (ph == 4 ? 6 : 20)
                random_word();
            drain();
        end

        // restore the default speed window for the last stretch
        send_idle_pct = 10;
        recv_stall_pct = 10;
        write_reg(REG_MIN, 16'd50);
        write_reg(REG_MAX, 16'd2500);
        write_reg(REG_GAP, 16'd20);
        write_reg(REG_TIMEOUT, 16'd15);
        repeat (20)
            random_word();
        drain();

        if (sb.errors == 0 && sb.pending() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end
endmodule
